// ===== rtl/phh_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_pkg: shared types and constants of the pulse height histogram
// Operation codes, register indexes, the command passed from the front end
// to the bin engine, and the result item.
// ----------------------------------------------------------------------------
package phh_pkg;

	localparam int NUM_BINS_DEF = 256;
	localparam int ADDR_W       = 12;
	localparam int CODE_W       = 12;
	localparam int SCALE_W      = 24;
	localparam int SCALE_FRAC   = 16;
	localparam int PROD_W       = CODE_W + SCALE_W;
	localparam int SCALED_W     = PROD_W - SCALE_FRAC;
	localparam int HIT_W        = 8;
	localparam int COUNT_W      = 16;

	localparam int CMD_DEPTH    = 4;
	localparam int OUT_DEPTH    = 4;
	localparam int OUT_LVL_W    = $clog2(OUT_DEPTH + 1);

	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 2'd2;

	localparam logic [CODE_W-1:0]  LOWER_RST = 12'd0;
	localparam logic [CODE_W-1:0]  UPPER_RST = 12'd4095;
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'h100000;

	localparam logic [1:0] OP_ADD   = 2'd0;
	localparam logic [1:0] OP_CLEAR = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_NONE,
		CMD_ADD,
		CMD_READ,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t         kind;
		logic [ADDR_W-1:0] addr;
		logic [HIT_W-1:0]  hit;
		logic              oor;
	} cmd_t;

	typedef struct packed {
		logic               oor;
		logic [HIT_W-1:0]   hit;
		logic [COUNT_W-1:0] count;
	} res_t;

	typedef enum logic [1:0] {
		BK_INIT,
		BK_RUN,
		BK_CLEAR
	} back_state_t;

endpackage
`default_nettype wire

// ===== rtl/pulse_height_histogram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_height_histogram: multichannel pulse height analyzer
// Bins ADC pulse amplitudes into NUM_BINS saturating 16-bit counts.
// ----------------------------------------------------------------------------
// Items enter on push/full: add a sample, clear all bins, or read a bin.
// Each item gives one result on empty/pop, in order: out_of_range, hit_bin
// and bin_count. The user must write registers (lower_code, upper_code,
// bin_scale) through cfg_wr_en/cfg_index/cfg_wdata only while no item is
// in flight; the block itself does not enforce this.
// Throughput: one add or read per cycle while full stays low; a clear holds
// the bin engine while it zeroes the count memory one bin a cycle.
// The rate is set by the single write port of the count memory; back-to-back
// adds to one bin are bypassed around its registered read.
// Reset: registers return to their defaults and the count memory is swept
// to zero, with full held high until the sweep ends.
// Stalls: a four-entry command queue and a four-entry result queue part the
// front end from the bin engine and the bin engine from the receiver; when
// pop is held low they fill and full rises, and no result is dropped.
// ----------------------------------------------------------------------------
module pulse_height_histogram #(
	parameter int NUM_BINS = phh_pkg::NUM_BINS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [phh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [phh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [1:0]                       operation,
	input  wire logic [phh_pkg::CODE_W-1:0]       sample_code,
	input  wire logic [phh_pkg::HIT_W-1:0]        bin_index,
	output logic                                  empty,
	input  wire logic                             pop,
	output logic                                  out_of_range,
	output logic      [phh_pkg::HIT_W-1:0]        hit_bin,
	output logic      [phh_pkg::COUNT_W-1:0]      bin_count
);

	phh_pkg::cmd_t                   cmd_in;
	phh_pkg::cmd_t                   cmd_out;
	logic                            cmd_push;
	logic                            cmd_pop;
	logic                            cmd_full;
	logic                            cmd_empty;
	logic [$clog2(phh_pkg::CMD_DEPTH+1)-1:0] cmd_level;

	phh_pkg::res_t                   res_in;
	phh_pkg::res_t                   res_out;
	logic                            res_push;
	logic                            res_full;
	logic [phh_pkg::OUT_LVL_W-1:0]   res_level;
	logic                            init_busy;
	logic                            cmd_over;

	phh_front #(
		.NUM_BINS (NUM_BINS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.operation   (operation),
		.sample_code (sample_code),
		.bin_index   (bin_index),
		.init_busy   (init_busy),
		.cmd_full    (cmd_full),
		.cmd_push    (cmd_push),
		.cmd         (cmd_in)
	);

	phh_fifo #(
		.WIDTH ($bits(phh_pkg::cmd_t)),
		.DEPTH (phh_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out),
		.empty   (cmd_empty),
		.full    (cmd_full),
		.level   (cmd_level)
	);

	phh_back #(
		.NUM_BINS (NUM_BINS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (cmd_empty),
		.cmd       (cmd_out),
		.cmd_pop   (cmd_pop),
		.res_level (res_level),
		.res_push  (res_push),
		.res       (res_in),
		.init_busy (init_busy)
	);

	phh_fifo #(
		.WIDTH ($bits(phh_pkg::res_t)),
		.DEPTH (phh_pkg::OUT_DEPTH)
	) u_res_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_out),
		.empty   (empty),
		.full    (res_full),
		.level   (res_level)
	);

	assign out_of_range = res_out.oor;
	assign hit_bin      = res_out.hit;
	assign bin_count    = res_out.count;
	assign cmd_over     = (cmd_level > ($clog2(phh_pkg::CMD_DEPTH+1))'(phh_pkg::CMD_DEPTH));

`ifndef SYNTH
	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result pushed into a full result queue");

	a_cmd_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command pushed into a full command queue");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> (!res_push && !cmd_pop))
		else $error("bin engine active during the reset sweep");

	a_cmd_level: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_over)
		else $error("command queue level out of range");
`endif

endmodule
`default_nettype wire

// ===== rtl/phh_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_fifo: small register queue
// Fall-through read of the oldest entry; reports its fill level.
// ----------------------------------------------------------------------------
module phh_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [WIDTH-1:0]             wr_data,
	input  wire logic                         rd_en,
	output logic      [WIDTH-1:0]             rd_data,
	output logic                              empty,
	output logic                              full,
	output logic      [$clog2(DEPTH+1)-1:0]   level
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_wr;
	logic             do_rd;

	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign empty   = (level_q == '0);
	assign full    = (level_q == LVL_W'(DEPTH));
	assign level   = level_q;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/phh_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_front: configuration and item classification
// Holds the window and scale registers, checks the window, scales the
// offset to a bin and hands a decoded command to the bin engine.
// ----------------------------------------------------------------------------
module phh_front #(
	parameter int NUM_BINS = phh_pkg::NUM_BINS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_wr_en,
	input  wire logic [phh_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [phh_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire logic                             push,
	output logic                                  full,
	input  wire logic [1:0]                       operation,
	input  wire logic [phh_pkg::CODE_W-1:0]       sample_code,
	input  wire logic [phh_pkg::HIT_W-1:0]        bin_index,
	input  wire logic                             init_busy,
	input  wire logic                             cmd_full,
	output logic                                  cmd_push,
	output phh_pkg::cmd_t                         cmd
);

	localparam logic [phh_pkg::SCALED_W-1:0] BIN_LAST = phh_pkg::SCALED_W'(NUM_BINS - 1);
	localparam logic [phh_pkg::ADDR_W:0]     BIN_CNT  = (phh_pkg::ADDR_W + 1)'(NUM_BINS);

	logic [phh_pkg::CODE_W-1:0]   lower_q;
	logic [phh_pkg::CODE_W-1:0]   upper_q;
	logic [phh_pkg::SCALE_W-1:0]  scale_q;

	logic                         valid_s1;
	logic [1:0]                   op_s1;
	logic                         oor_s1;
	logic [phh_pkg::CODE_W-1:0]   offset_s1;
	logic [phh_pkg::HIT_W-1:0]    idx_s1;

	logic                         valid_s2;
	logic [1:0]                   op_s2;
	logic                         oor_s2;
	logic [phh_pkg::PROD_W-1:0]   prod_s2;
	logic [phh_pkg::HIT_W-1:0]    idx_s2;

	logic                         ready_s1;
	logic                         ready_s2;
	logic                         accept;
	logic [phh_pkg::SCALED_W-1:0] scaled;
	logic [phh_pkg::SCALED_W-1:0] bin_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= phh_pkg::LOWER_RST;
			upper_q <= phh_pkg::UPPER_RST;
			scale_q <= phh_pkg::SCALE_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				phh_pkg::CFG_LOWER: lower_q <= cfg_wdata[phh_pkg::CODE_W-1:0];
				phh_pkg::CFG_UPPER: upper_q <= cfg_wdata[phh_pkg::CODE_W-1:0];
				phh_pkg::CFG_SCALE: scale_q <= cfg_wdata[phh_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign ready_s2 = !valid_s2 || !cmd_full;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign full     = !ready_s1 || init_busy;
	assign accept   = push && !full;
	assign cmd_push = valid_s2 && !cmd_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= accept;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1     <= operation;
			oor_s1    <= (sample_code < lower_q) || (sample_code > upper_q);
			offset_s1 <= sample_code - lower_q;
			idx_s1    <= bin_index;
		end
		if (valid_s1 && ready_s2) begin
			op_s2   <= op_s1;
			oor_s2  <= oor_s1;
			prod_s2 <= phh_pkg::PROD_W'(offset_s1) * phh_pkg::PROD_W'(scale_q);
			idx_s2  <= idx_s1;
		end
	end

	assign scaled  = prod_s2[phh_pkg::PROD_W-1:phh_pkg::SCALE_FRAC];
	assign bin_sat = (scaled > BIN_LAST) ? BIN_LAST : scaled;

	always_comb begin
		cmd = '0;
		unique case (op_s2)
			phh_pkg::OP_ADD: begin
				if (oor_s2) begin
					cmd.kind = phh_pkg::CMD_NONE;
					cmd.oor  = 1'b1;
				end else begin
					cmd.kind = phh_pkg::CMD_ADD;
					cmd.addr = bin_sat[phh_pkg::ADDR_W-1:0];
					cmd.hit  = bin_sat[phh_pkg::HIT_W-1:0];
				end
			end
			phh_pkg::OP_CLEAR: begin
				cmd.kind = phh_pkg::CMD_CLEAR;
			end
			phh_pkg::OP_READ: begin
				cmd.hit = idx_s2;
				if ((phh_pkg::ADDR_W + 1)'(idx_s2) < BIN_CNT) begin
					cmd.kind = phh_pkg::CMD_READ;
					cmd.addr = phh_pkg::ADDR_W'(idx_s2);
				end else begin
					cmd.kind = phh_pkg::CMD_NONE;
				end
			end
			default: begin
				cmd.kind = phh_pkg::CMD_NONE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/phh_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// phh_back: bin engine
// Owns the count memory: read-modify-write with saturation, bin reads and
// the clearing sweep after reset and on a clear command.
// ----------------------------------------------------------------------------
module phh_back #(
	parameter int NUM_BINS = phh_pkg::NUM_BINS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cmd_empty,
	input  wire phh_pkg::cmd_t                   cmd,
	output logic                                 cmd_pop,
	input  wire logic [phh_pkg::OUT_LVL_W-1:0]   res_level,
	output logic                                 res_push,
	output phh_pkg::res_t                        res,
	output logic                                 init_busy
);

	localparam int BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
	localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);
	localparam logic [phh_pkg::OUT_LVL_W-1:0] OUT_LIMIT =
		phh_pkg::OUT_LVL_W'(phh_pkg::OUT_DEPTH);

	phh_pkg::back_state_t state_q;
	phh_pkg::back_state_t state_d;

	logic [phh_pkg::COUNT_W-1:0] mem_q [NUM_BINS];
	logic [BIN_W-1:0]            sweep_q;
	logic                        sweeping;
	logic                        sweep_last;
	logic                        credit;
	logic                        start_clear;

	logic                        valid_s1;
	phh_pkg::cmd_t               cmd_s1;
	logic [phh_pkg::COUNT_W-1:0] rd_data_s1;

	logic                        fwd_valid_q;
	logic [BIN_W-1:0]            fwd_addr_q;
	logic [phh_pkg::COUNT_W-1:0] fwd_data_q;

	logic [BIN_W-1:0]            rd_addr;
	logic [BIN_W-1:0]            addr_s1;
	logic [phh_pkg::COUNT_W-1:0] old_count;
	logic [phh_pkg::COUNT_W-1:0] new_count;
	logic                        add_wr;
	logic                        wr_en;
	logic [BIN_W-1:0]            wr_addr;
	logic [phh_pkg::COUNT_W-1:0] wr_data;

	assign sweeping    = (state_q != phh_pkg::BK_RUN);
	assign sweep_last  = (sweep_q == LAST_BIN);
	assign init_busy   = (state_q == phh_pkg::BK_INIT);
	assign credit      = (res_level + phh_pkg::OUT_LVL_W'(valid_s1)) < OUT_LIMIT;
	assign cmd_pop     = (state_q == phh_pkg::BK_RUN) && !cmd_empty && credit;
	assign start_clear = cmd_pop && (cmd.kind == phh_pkg::CMD_CLEAR);
	assign rd_addr     = cmd.addr[BIN_W-1:0];
	assign addr_s1     = cmd_s1.addr[BIN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phh_pkg::BK_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			phh_pkg::BK_INIT: begin
				if (sweep_last) begin
					state_d = phh_pkg::BK_RUN;
				end
			end
			phh_pkg::BK_RUN: begin
				if (start_clear) begin
					state_d = phh_pkg::BK_CLEAR;
				end
			end
			phh_pkg::BK_CLEAR: begin
				if (sweep_last) begin
					state_d = phh_pkg::BK_RUN;
				end
			end
			default: begin
				state_d = phh_pkg::BK_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q     <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
		end else begin
			if (sweeping) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
			end
			valid_s1 <= cmd_pop && !start_clear;
			if (sweeping) begin
				fwd_valid_q <= 1'b0;
			end else if (add_wr) begin
				fwd_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_s1 <= cmd;
		end
		if (add_wr) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_count;
		end
	end

	// count memory, registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (cmd_pop) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	// bypass the write that lands on the same edge as the read
	assign old_count = (fwd_valid_q && (fwd_addr_q == addr_s1)) ? fwd_data_q : rd_data_s1;
	assign new_count = (old_count == phh_pkg::COUNT_MAX) ? old_count : old_count + 1'b1;
	assign add_wr    = valid_s1 && (cmd_s1.kind == phh_pkg::CMD_ADD);
	assign wr_en     = sweeping || add_wr;
	assign wr_addr   = sweeping ? sweep_q : addr_s1;
	assign wr_data   = sweeping ? '0 : new_count;

	assign res_push = valid_s1 || ((state_q == phh_pkg::BK_CLEAR) && sweep_last);

	always_comb begin
		res = '0;
		if (valid_s1) begin
			res.oor = cmd_s1.oor;
			res.hit = cmd_s1.hit;
			case (cmd_s1.kind)
				phh_pkg::CMD_ADD:  res.count = new_count;
				phh_pkg::CMD_READ: res.count = old_count;
				default:           res.count = '0;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/pulse_height_histogram_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_height_histogram_test: self-checking bench for the pulse height histogram
// Sends add, clear, read and spare-code items and keeps a shadow copy of the
// bin counts and window registers. Each popped result is checked against the
// prediction made when its item was taken. Directed tests cover the defaults,
// window edges, scale extremes and repeated hits on one bin. Random tests run
// under three idling patterns.
// ----------------------------------------------------------------------------
module pulse_height_histogram_test;
	import phh_pkg::*;

	localparam int BINS = NUM_BINS_DEF;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
	localparam logic [1:0] OP_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_LOWER;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            operation = OP_ADD;
	logic [CODE_W-1:0]     sample_code = '0;
	logic [HIT_W-1:0]      bin_index = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic                  out_of_range;
	logic [HIT_W-1:0]      hit_bin;
	logic [COUNT_W-1:0]    bin_count;

	logic [COUNT_W-1:0] shadow_counts [BINS];
	logic [CODE_W-1:0]  win_lower = LOWER_RST;
	logic [CODE_W-1:0]  win_upper = UPPER_RST;
	logic [SCALE_W-1:0] win_scale = SCALE_RST;
	logic [HIT_W-1:0]   recent_bin = '0;
	res_t               bin_reports_due [$];
	int                 send_idle_pct = 0;
	int                 recv_idle_pct = 0;
	int                 fail_count = 0;

	pulse_height_histogram dut (.*);

	always #1 clk = ~clk;

	function automatic res_t histogram_step(input logic [1:0] op,
			input logic [CODE_W-1:0] code, input logic [HIT_W-1:0] idx);
		res_t                r;
		logic [PROD_W-1:0]   product;
		logic [SCALED_W-1:0] scaled;
		int                  b;
		r = '0;
		case (op)
			OP_ADD: begin
				if (code < win_lower || code > win_upper) begin
					r.oor = 1'b1;
				end else begin
					product = PROD_W'(code - win_lower) * PROD_W'(win_scale);
					scaled = SCALED_W'(product >> SCALE_FRAC);
					b = (scaled > SCALED_W'(BINS - 1)) ? BINS - 1 : int'(scaled);
					if (shadow_counts[b] != COUNT_MAX)
						shadow_counts[b] = shadow_counts[b] + 1'b1;
					r.hit = HIT_W'(b);
					r.count = shadow_counts[b];
					recent_bin = HIT_W'(b);
				end
			end
			OP_CLEAR: begin
				foreach (shadow_counts[i])
					shadow_counts[i] = '0;
			end
			OP_READ: begin
				r.hit = idx;
				if (int'(idx) < BINS)
					r.count = shadow_counts[idx];
			end
			default: ;
		endcase
		return r;
	endfunction

	// push stays high after acceptance; the next call or wait_quiet decides
	task automatic put_item(input logic [1:0] op, input logic [CODE_W-1:0] code,
			input logic [HIT_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		operation <= op;
		sample_code <= code;
		bin_index <= idx;
		@(posedge clk);
		while (full)
			@(posedge clk);
		bin_reports_due.push_back(histogram_step(op, code, idx));
	endtask

	task automatic wait_quiet();
		push <= 1'b0;
		@(posedge clk);
		while (bin_reports_due.size() != 0 || full)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_quiet();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			CFG_LOWER: win_lower = data[CODE_W-1:0];
			CFG_UPPER: win_upper = data[CODE_W-1:0];
			CFG_SCALE: win_scale = data[SCALE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic test_defaults();
		put_item(OP_ADD, 12'd0, 8'd0);
		put_item(OP_ADD, 12'd4095, 8'd0);
		put_item(OP_ADD, 12'd15, 8'd0);
		put_item(OP_READ, 12'd0, 8'd255);
		put_item(OP_READ, 12'd4095, 8'd128);
		put_item(OP_SPARE, 12'd4095, 8'd255);
		put_item(OP_CLEAR, 12'd0, 8'd0);
		put_item(OP_READ, 12'd0, 8'd240);
	endtask

	task automatic test_window();
		write_reg(CFG_LOWER, 24'hABC064);
		write_reg(CFG_UPPER, 24'h0000C8);
		write_reg(CFG_SCALE, 24'h010000);
		put_item(OP_ADD, 12'd99, 8'd0);
		put_item(OP_ADD, 12'd100, 8'd0);
		put_item(OP_ADD, 12'd200, 8'd0);
		put_item(OP_ADD, 12'd201, 8'd0);
		put_item(OP_READ, 12'd0, 8'd100);
		// empty window: lower above upper
		write_reg(CFG_LOWER, 24'd300);
		put_item(OP_ADD, 12'd250, 8'd0);
		write_reg(CFG_LOWER, 24'd4095);
		write_reg(CFG_UPPER, 24'hFFFFFF);
		put_item(OP_ADD, 12'd4095, 8'd0);
		put_item(OP_ADD, 12'd0, 8'd0);
	endtask

	task automatic test_scale_extremes();
		write_reg(CFG_LOWER, 24'd0);
		write_reg(CFG_SCALE, 24'd0);
		put_item(OP_ADD, 12'd4095, 8'd0);
		write_reg(CFG_SCALE, 24'hFFFFFF);
		put_item(OP_ADD, 12'd1, 8'd0);
		put_item(OP_ADD, 12'd0, 8'd0);
		write_reg(CFG_SPARE, 24'h000000);
		put_item(OP_ADD, 12'd1, 8'd0);
	endtask

	task automatic test_one_bin();
		write_reg(CFG_LOWER, 24'd0);
		write_reg(CFG_UPPER, 24'd4095);
		write_reg(CFG_SCALE, 24'h010000);
		put_item(OP_CLEAR, 12'd0, 8'd0);
		for (int i = 0; i < 48; i++)
			put_item(OP_ADD, 12'd77, 8'd0);
		put_item(OP_READ, 12'd0, 8'd77);
		put_item(OP_READ, 12'd0, 8'd78);
		wait_quiet();
	endtask

	task automatic pick_window();
		int                    lo;
		int                    hi;
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] scl;
		junk = CFG_DATA_W'($urandom());
		case ($urandom_range(7))
			0: begin
				lo = $urandom_range(1, 4095);
				hi = $urandom_range(0, lo - 1);
			end
			1: begin
				lo = 0;
				hi = 4095;
			end
			default: begin
				lo = $urandom_range(0, 3500);
				hi = $urandom_range(lo, 4095);
			end
		endcase
		case ($urandom_range(4))
			0: scl = CFG_DATA_W'($urandom());
			1: scl = ($urandom_range(1) == 1) ? 24'hFFFFFF : 24'h000000;
			2: scl = CFG_DATA_W'($urandom_range(0, 24'h03FFFF));
			default: scl = (hi >= lo) ? CFG_DATA_W'((BINS << SCALE_FRAC) / (hi - lo + 1))
				: 24'h010000;
		endcase
		write_reg(CFG_LOWER, {junk[11:0], 12'(lo)});
		write_reg(CFG_UPPER, {junk[23:12], 12'(hi)});
		write_reg(CFG_SCALE, scl);
		if ($urandom_range(3) == 0)
			write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
	endtask

	task automatic test_random(input int n_items);
		int                r;
		logic [1:0]        op;
		logic [CODE_W-1:0] code;
		logic [HIT_W-1:0]  idx;
		for (int part = 0; part < 3; part++) begin
			pick_window();
			for (int i = 0; i < n_items / 3; i++) begin
				r = $urandom_range(99);
				if (win_lower <= win_upper && r < 75)
					code = CODE_W'($urandom_range(win_lower, win_upper));
				else if (r < 87)
					case ($urandom_range(3))
						0: code = win_lower;
						1: code = win_upper;
						2: code = win_lower - 1'b1;
						default: code = win_upper + 1'b1;
					endcase
				else
					code = CODE_W'($urandom());
				idx = ($urandom_range(1) == 1) ? recent_bin : HIT_W'($urandom());
				r = $urandom_range(99);
				if (r < 78)
					op = OP_ADD;
				else if (r < 93)
					op = OP_READ;
				else if (r < 97)
					op = OP_SPARE;
				else
					op = OP_CLEAR;
				put_item(op, code, idx);
				if ($urandom_range(199) == 0)
					wait_quiet();
			end
		end
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && pop && !empty) begin
			got = {out_of_range, hit_bin, bin_count};
			if (bin_reports_due.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected result: oor %0d hit %0d count %0d",
						got.oor, got.hit, got.count);
			end else begin
				want = bin_reports_due.pop_front();
				if (got.oor !== want.oor || got.hit !== want.hit
						|| got.count !== want.count) begin
					fail_count++;
					if (fail_count <= 10)
						$display("mismatch: expected oor %0d hit %0d count %0d, got oor %0d hit %0d count %0d",
							want.oor, want.hit, want.count, got.oor, got.hit, got.count);
				end
			end
		end
		pop <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		foreach (shadow_counts[i])
			shadow_counts[i] = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 20;
		recv_idle_pct = 64;
		test_defaults();
		test_window();
		test_scale_extremes();
		test_random(333);
		send_idle_pct = 64;
		recv_idle_pct = 20;
		test_random(333);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_one_bin();
		test_random(333);
		wait_quiet();
		repeat (16) @(posedge clk);
		fail_count += bin_reports_due.size();
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		#4000000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/phh_pkg.sv
rtl/phh_fifo.sv
rtl/phh_front.sv
rtl/phh_back.sv
rtl/pulse_height_histogram.sv
tb/sv/pulse_height_histogram_test.sv
